// ===== hdl/sss_pkg.sv =====
package sss_pkg;

  localparam int unsigned SAMPLE_W        = 24;
  localparam int unsigned CHANGE_W        = 25;
  localparam int unsigned SPREAD_W        = 24;
  localparam int unsigned SCORE_W         = 16;
  localparam int unsigned RANK_W          = 7;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned PERCENT_SCALE   = 200;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FLAT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_SQRT_LOAD,
    ST_SQRT_RUN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_SPREAD,
    DIV_SCORE,
    DIV_RANK
  } div_op_e;

endpackage

// ===== hdl/sss_ram.sv =====
module sss_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/series_summary_statistics_top.sv =====
// channel   direction  handshake            payload
// request   in         start_i / busy_o     sample_i, last_sample_i
// result    out        valid_o (one cycle)  current_value_o .. status_o
//
// a request without last_sample_i adds its sample to the series; busy_o stays low
// the request with last_sample_i holds busy_o high through a walk of the
// sample memory, a shift-add multiplier, a digit square root and a
// restoring divider, all one bit a cycle
// reset clears the series; the result is valid for one cycle and cannot stall
module series_summary_statistics_top #(
  parameter int unsigned MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_sample_i,
  output logic                                valid_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0] current_value_o,
  output logic signed [sss_pkg::CHANGE_W-1:0] change_value_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0] mean_value_o,
  output logic        [sss_pkg::SPREAD_W-1:0] spread_value_o,
  output logic signed [sss_pkg::SCORE_W-1:0]  score_value_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0] min_value_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0] max_value_o,
  output logic        [sss_pkg::RANK_W-1:0]   rank_percent_o,
  output logic        [sss_pkg::STATUS_W-1:0] status_o
);

  import sss_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned SUMW = SAMPLE_W + CW;
  localparam int unsigned SQW  = 2 * SAMPLE_W - 1 + CW;
  localparam int unsigned PW   = 2 * SAMPLE_W - 1 + 2 * CW;
  localparam int unsigned TW   = (PW + 3) / 2;
  localparam int unsigned MAW  = SUMW - 1;
  localparam int unsigned DVW  = SUMW + 11;
  localparam int unsigned DSW  = TW + 1;
  localparam int unsigned CNTW = $clog2(MAX_SAMPLES + DVW + 1);

  state_e  state_q, state_d;
  div_op_e div_op_q;
  logic    mul_sec_q;

  logic                       accept;
  logic                       store_ok;
  logic [CW-1:0]              count_q;
  logic signed [SUMW-1:0]     sum_q;
  logic [SQW-1:0]             sqsum_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q, prev_q, last_q;
  logic                       ovf_q;
  logic signed [2*SAMPLE_W-1:0] sq;

  logic [CNTW-1:0]     cnt_q;
  logic                pend_q;
  logic [CW-1:0]       lt_q;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic [MAW-1:0]          s1abs_q;
  logic signed [SUMW:0]    nl_q;
  logic signed [SUMW:0]    dd;
  logic [SUMW:0]           dabs_q;
  logic                    dneg_q;

  logic [MAW-1:0] ma_q;
  logic [PW-1:0]  mb_q, acc_q, p1_q, vdiff;

  logic [2*TW-1:0] rad_q;
  logic [TW-1:0]   root_q;
  logic [TW+1:0]   srem_q, sr, strial;
  logic            vzero_q;

  logic [DVW-1:0] dvd_q;
  logic [DSW-1:0] dsr_q;
  logic [DSW-1:0] rem_q;
  logic [DSW:0]   dr, ddiff;

  logic signed [SAMPLE_W-1:0] mean_q;
  logic [SPREAD_W-1:0]        spread_q;
  logic signed [SCORE_W-1:0]  score_q;
  logic [RANK_W-1:0]          rank_q;
  logic [DVW:0]               qinc;

  assign accept   = start_i && !busy_o;
  assign store_ok = count_q < CW'(MAX_SAMPLES);
  assign sq       = sample_i * sample_i;
  assign busy_o   = state_q != ST_IDLE;

  sss_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept && store_ok),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(sample_i),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_sample_i) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cnt_q + CNTW'(1) == CNTW'(count_q)) begin
          state_d = ST_MUL_LOAD;
        end
      end
      ST_MUL_LOAD: state_d = ST_MUL_RUN;
      ST_MUL_RUN: begin
        if (cnt_q == CNTW'(MAW - 1)) begin
          state_d = mul_sec_q ? ST_SQRT_LOAD : ST_MUL_LOAD;
        end
      end
      ST_SQRT_LOAD: state_d = ST_SQRT_RUN;
      ST_SQRT_RUN: begin
        if (cnt_q == CNTW'(TW - 1)) begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (cnt_q == CNTW'(DVW - 1)) begin
          state_d = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: state_d = (div_op_q == DIV_RANK) ? ST_FIN : ST_DIV_LOAD;
      ST_FIN:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // series accumulators and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      min_q   <= SAMPLE_MAX;
      max_q   <= SAMPLE_MIN;
      prev_q  <= '0;
      last_q  <= '0;
      ovf_q   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= state_q == ST_FIN;
      if (accept) begin
        if (store_ok) begin
          count_q <= count_q + CW'(1);
          sum_q   <= sum_q + SUMW'(sample_i);
          sqsum_q <= sqsum_q + SQW'(sq[2*SAMPLE_W-2:0]);
          if (sample_i < min_q) begin
            min_q <= sample_i;
          end
          if (sample_i > max_q) begin
            max_q <= sample_i;
          end
          prev_q <= last_q;
          last_q <= sample_i;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == ST_FIN) begin
        count_q <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
        min_q   <= SAMPLE_MAX;
        max_q   <= SAMPLE_MIN;
        prev_q  <= '0;
        last_q  <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  assign dd     = nl_q - (SUMW + 1)'(sum_q);
  assign vdiff  = p1_q - acc_q;
  assign sr     = {srem_q[TW-1:0], rad_q[2*TW-1 -: 2]};
  assign strial = {root_q, 2'b01};
  assign dr     = {rem_q, dvd_q[DVW-1]};
  assign ddiff  = dr - {1'b0, dsr_q};
  assign qinc   = {1'b0, dvd_q} + (DVW + 1)'(1);

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    s1abs_q <= sum_q[SUMW-1] ? MAW'(-sum_q) : MAW'(sum_q);
    nl_q    <= $signed({1'b0, count_q}) * last_q;
    dabs_q  <= dd[SUMW] ? (SUMW + 1)'(-dd) : (SUMW + 1)'(dd);
    dneg_q  <= dd[SUMW];
    pend_q  <= state_q == ST_WALK;
    if (pend_q && ($signed(ram_rdata) < last_q)) begin
      lt_q <= lt_q + CW'(1);
    end
    case (state_q)
      ST_IDLE: begin
        cnt_q     <= '0;
        lt_q      <= '0;
        mul_sec_q <= 1'b0;
      end
      ST_WALK: cnt_q <= cnt_q + CNTW'(1);
      ST_MUL_LOAD: begin
        cnt_q <= '0;
        acc_q <= '0;
        if (mul_sec_q) begin
          p1_q <= acc_q;
          ma_q <= s1abs_q;
          mb_q <= PW'(s1abs_q);
        end else begin
          ma_q <= MAW'(count_q);
          mb_q <= PW'(sqsum_q);
        end
      end
      ST_MUL_RUN: begin
        cnt_q <= cnt_q + CNTW'(1);
        if (ma_q[0]) begin
          acc_q <= acc_q + mb_q;
        end
        ma_q <= ma_q >> 1;
        mb_q <= mb_q << 1;
        if (cnt_q == CNTW'(MAW - 1)) begin
          mul_sec_q <= 1'b1;
        end
      end
      ST_SQRT_LOAD: begin
        cnt_q    <= '0;
        rad_q    <= (2 * TW)'({vdiff, 2'b00});
        vzero_q  <= vdiff == '0;
        root_q   <= '0;
        srem_q   <= '0;
        div_op_q <= DIV_MEAN;
      end
      ST_SQRT_RUN: begin
        cnt_q <= cnt_q + CNTW'(1);
        rad_q <= rad_q << 2;
        if (sr >= strial) begin
          srem_q <= sr - strial;
          root_q <= {root_q[TW-2:0], 1'b1};
        end else begin
          srem_q <= sr;
          root_q <= {root_q[TW-2:0], 1'b0};
        end
      end
      ST_DIV_LOAD: begin
        cnt_q <= '0;
        rem_q <= '0;
        case (div_op_q)
          DIV_MEAN: begin
            dvd_q <= DVW'({s1abs_q, 1'b0}) + DVW'(count_q);
            dsr_q <= DSW'({count_q, 1'b0});
          end
          DIV_SPREAD: begin
            dvd_q <= DVW'(root_q);
            dsr_q <= DSW'(count_q);
          end
          DIV_SCORE: begin
            dvd_q <= DVW'({dabs_q, 10'b0}) + DVW'(root_q);
            dsr_q <= DSW'({root_q, 1'b0});
          end
          default: begin
            dvd_q <= DVW'(lt_q) * DVW'(PERCENT_SCALE) + DVW'(count_q);
            dsr_q <= DSW'({count_q, 1'b0});
          end
        endcase
      end
      ST_DIV_RUN: begin
        cnt_q <= cnt_q + CNTW'(1);
        if (!ddiff[DSW]) begin
          rem_q <= ddiff[DSW-1:0];
          dvd_q <= {dvd_q[DVW-2:0], 1'b1};
        end else begin
          rem_q <= dr[DSW-1:0];
          dvd_q <= {dvd_q[DVW-2:0], 1'b0};
        end
      end
      ST_DIV_DONE: begin
        case (div_op_q)
          DIV_MEAN: begin
            mean_q   <= sum_q[SUMW-1] ? -SAMPLE_W'(dvd_q) : SAMPLE_W'(dvd_q);
            div_op_q <= DIV_SPREAD;
          end
          DIV_SPREAD: begin
            spread_q <= (qinc[DVW:1] > DVW'(2 ** SPREAD_W - 1)) ? '1
                                                              : SPREAD_W'(qinc[DVW:1]);
            div_op_q <= DIV_SCORE;
          end
          DIV_SCORE: begin
            if (root_q == '0) begin
              score_q <= '0;
            end else if (dneg_q) begin
              score_q <= (dvd_q > DVW'(2 ** (SCORE_W - 1))) ? {1'b1, {(SCORE_W - 1){1'b0}}}
                                                           : -SCORE_W'(dvd_q);
            end else begin
              score_q <= (dvd_q > DVW'(2 ** (SCORE_W - 1) - 1))
                         ? {1'b0, {(SCORE_W - 1){1'b1}}} : SCORE_W'(dvd_q);
            end
            div_op_q <= DIV_RANK;
          end
          default: rank_q <= RANK_W'(dvd_q);
        endcase
      end
      ST_FIN: begin
        current_value_o <= last_q;
        change_value_o  <= (count_q < CW'(2)) ? '0
                           : (CHANGE_W'(last_q) - CHANGE_W'(prev_q));
        mean_value_o    <= mean_q;
        spread_value_o  <= spread_q;
        score_value_o   <= score_q;
        min_value_o     <= min_q;
        max_value_o     <= max_q;
        rank_percent_o  <= rank_q;
        if (ovf_q) begin
          status_o <= STATUS_DROP;
        end else if (count_q < CW'(2)) begin
          status_o <= STATUS_FEW;
        end else if (vzero_q) begin
          status_o <= STATUS_FLAT;
        end else begin
          status_o <= STATUS_OK;
        end
      end
      default: cnt_q <= cnt_q;
    endcase
  end

endmodule

// ===== hdl/sss_checker.sv =====
module sss_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                last_sample_i,
  input logic                                valid_o,
  input logic signed [sss_pkg::CHANGE_W-1:0] change_value_o,
  input logic        [sss_pkg::SPREAD_W-1:0] spread_value_o,
  input logic signed [sss_pkg::SCORE_W-1:0]  score_value_o,
  input logic        [sss_pkg::RANK_W-1:0]   rank_percent_o,
  input logic        [sss_pkg::STATUS_W-1:0] status_o
);

  import sss_pkg::*;

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while busy");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_sample_i) |=> busy_o)
    else $error("last request did not start the summary");

  a_plain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_sample_i) |=> !valid_o && !busy_o)
    else $error("plain request produced a result or stalled");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rank_percent_o <= RANK_W'(100))
    else $error("rank above one hundred");

  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_FEW) |->
      (change_value_o == '0 && spread_value_o == '0 && score_value_o == '0))
    else $error("single sample result not zeroed");

endmodule

bind series_summary_statistics_top sss_checker u_sss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_sample_i  (last_sample_i),
  .valid_o        (valid_o),
  .change_value_o (change_value_o),
  .spread_value_o (spread_value_o),
  .score_value_o  (score_value_o),
  .rank_percent_o (rank_percent_o),
  .status_o       (status_o)
);

// ===== dv/series_summary_statistics_top_tb.sv =====
module series_summary_statistics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_SAMPLES_DEF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] current;
    logic signed [CHANGE_W-1:0] change;
    logic signed [SAMPLE_W-1:0] mean;
    logic        [SPREAD_W-1:0] spread;
    logic signed [SCORE_W-1:0]  score;
    logic signed [SAMPLE_W-1:0] min;
    logic signed [SAMPLE_W-1:0] max;
    logic        [RANK_W-1:0]   rank;
    logic        [STATUS_W-1:0] status;
  } summary_t;

  class stats_scoreboard;
    longint   store_q[STORE_DEPTH];
    longint   count;
    longint   total;
    longint   square_total;
    longint   lowest;
    longint   highest;
    longint   prior;
    bit       dropped;
    summary_t summaries[$];
    int       mismatches;
    int       failures;

    function new();
      mismatches = 0;
      failures   = 0;
      clear_series();
    endfunction

    function void clear_series();
      count        = 0;
      total        = 0;
      square_total = 0;
      lowest       = 8388607;
      highest      = -8388608;
      prior        = 0;
      dropped      = 0;
    endfunction

    function logic [127:0] root_floor(logic [127:0] v);
      logic [127:0] res;
      logic [127:0] one;
      logic [127:0] trial;
      res = '0;
      one = 128'd1 << 126;
      while (one != 0) begin
        trial = res + one;
        if (v >= trial) begin
          v   = v - trial;
          res = (res >> 1) + one;
        end else begin
          res = res >> 1;
        end
        one = one >> 2;
      end
      return res;
    endfunction

    function void note_request(logic signed [SAMPLE_W-1:0] sample, logic last);
      longint       x;
      longint       latest;
      longint       mag;
      longint       t;
      longint       d;
      longint       q;
      longint       spread;
      longint       below;
      logic [127:0] var_n;
      summary_t     s;
      x = longint'(sample);
      if (count < STORE_DEPTH) begin
        if (count > 0) prior = store_q[count-1];
        store_q[count] = x;
        count++;
        total += x;
        square_total += x * x;
        if (x < lowest) lowest = x;
        if (x > highest) highest = x;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      latest = store_q[count-1];
      mag = (total < 0) ? -total : total;
      mag = (2 * mag + count) / (2 * count);
      s = '0;
      s.current = SAMPLE_W'(latest);
      s.mean = SAMPLE_W'((total < 0) ? -mag : mag);
      var_n = '0;
      if (count >= 2) begin
        mag = (total < 0) ? -total : total;
        var_n = 128'(count) * 128'(square_total) - 128'(mag) * 128'(mag);
        s.change = CHANGE_W'(latest - prior);
        t = longint'(root_floor(var_n << 2));
        spread = ((t / count) + 1) >> 1;
        s.spread = (spread > 64'hffffff) ? 24'hffffff : SPREAD_W'(spread);
        if (t != 0) begin
          d = count * latest - total;
          q = (d < 0) ? -d : d;
          q = (2 * q * 512 + t) / (2 * t);
          if (d < 0) s.score = SCORE_W'((q > 32768) ? -32768 : -q);
          else s.score = SCORE_W'((q > 32767) ? 32767 : q);
        end
      end
      below = 0;
      for (int i = 0; i < count; i++)
        if (store_q[i] < latest) below++;
      s.min  = SAMPLE_W'(lowest);
      s.max  = SAMPLE_W'(highest);
      s.rank = RANK_W'((200 * below + count) / (2 * count));
      if (dropped) s.status = STATUS_DROP;
      else if (count < 2) s.status = STATUS_FEW;
      else if (var_n == 0) s.status = STATUS_FLAT;
      else s.status = STATUS_OK;
      summaries = {summaries, s};
      clear_series();
    endfunction

    function void check_result(summary_t got);
      summary_t want;
      if (summaries.size() == 0) begin
        failures++;
        $display("unexpected result at %0t", $realtime);
        return;
      end
      want = summaries.pop_front();
      if (got !== want) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp cur %0d chg %0d mean %0d sd %0d z %0d min %0d max %0d rk %0d st %0d",
                   want.current, want.change, want.mean, want.spread, want.score,
                   want.min, want.max, want.rank, want.status);
          $display("         got cur %0d chg %0d mean %0d sd %0d z %0d min %0d max %0d rk %0d st %0d",
                   got.current, got.change, got.mean, got.spread, got.score,
                   got.min, got.max, got.rank, got.status);
        end
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       last_sample_i;
  logic                       valid_o;
  summary_t                   result;

  series_summary_statistics_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .valid_o        (valid_o),
    .current_value_o(result.current),
    .change_value_o (result.change),
    .mean_value_o   (result.mean),
    .spread_value_o (result.spread),
    .score_value_o  (result.score),
    .min_value_o    (result.min),
    .max_value_o    (result.max),
    .rank_percent_o (result.rank),
    .status_o       (result.status)
  );

  stats_scoreboard stats = new();
  int burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) stats.check_result(result);
  end

  // bursts of back-to-back requests, most separated by random idle gaps
  task automatic send(logic signed [SAMPLE_W-1:0] sample, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i       <= 1'b1;
    sample_i      <= sample;
    last_sample_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    stats.note_request(sample, last);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode, int base);
    case (mode)
      0: return SAMPLE_W'($urandom());
      1: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      2: return SAMPLE_W'(base + $signed($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'(base);
    endcase
  endfunction

  task automatic send_series(int len, int mode);
    int base;
    base = $signed(24'($urandom()));
    for (int i = 0; i < len; i++) send(pick_sample(mode, base), i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    start_i       = 1'b0;
    sample_i      = '0;
    last_sample_i = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single samples, then extremes, flat series, negative rounding, outlier, a short mixed series
    send(SAMPLE_MAX, 1'b1);
    send(SAMPLE_MIN, 1'b1);
    send(SAMPLE_MIN, 1'b0);
    send(SAMPLE_MAX, 1'b1);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b1);
    for (int i = 0; i < 4; i++) send(-24'sd77, i == 3);
    send(-24'sd1, 1'b0);
    send(-24'sd2, 1'b1);
    for (int i = 0; i < 8; i++) send((i == 7) ? 24'sd100000 : 24'sd0, i == 7);
    send(24'sd5, 1'b0);
    send(24'sd3, 1'b0);
    send(24'sd5, 1'b1);

    // one series past capacity so samples get dropped
    send_series(STORE_DEPTH + 6, 0);

    sent = 0;
    while (sent < 500) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      send_series(len, $urandom_range(0, 3));
      sent += len;
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (stats.summaries.size() != 0 || busy_o) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (stats.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
